// File: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the multirate tick scheduler
// Register indexes, command codes, field widths and the control and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

	// Tick set and field widths
	localparam int NUM_TICKS     = 10;
	localparam int PERIOD_BITS   = 12;
	localparam int TICKS_PER_REG = 5;
	localparam int REG_BITS      = TICKS_PER_REG * PERIOD_BITS;
	localparam int CONN_BITS     = NUM_TICKS;
	localparam int STEP_BITS     = 32;
	localparam int MAX_RUN       = 64;
	localparam int RUN_BITS      = 7;
	localparam int DIV_CNT_BITS  = $clog2(STEP_BITS);

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = REG_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_PERIODS_LOW  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIODS_HIGH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONNECTED    = 2'd2;

	// Command codes
	localparam logic OP_RUN    = 1'b0;
	localparam logic OP_REINIT = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic div_start;    // load step counter into the residue divider
		logic div_step;     // one bit of residue recompute
		logic div_done;     // residues are current again
		logic step_fire;    // advance one base step and load a result
		logic reinit_fire;  // clear counters and load the reinit result
		logic last;         // last flag for the result being loaded
	} mts_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;     // output register can take a result this cycle
		logic stale;        // residues must be recomputed before a run
	} mts_sts_t;

endpackage

// File: sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl: command sequencer of the multirate tick scheduler
// Accepts commands, runs the residue recompute when periods changed, and
// paces the per-step results against the output register.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [mts_pkg::RUN_BITS-1:0]      run_steps,
	input  mts_pkg::mts_sts_t                 sts,
	output mts_pkg::mts_cmd_t                 cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIV    = 4'b0010,
		ST_RUN    = 4'b0100,
		ST_REINIT = 4'b1000
	} mts_state_t;

	localparam logic [mts_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
		mts_pkg::DIV_CNT_BITS'(mts_pkg::STEP_BITS - 1);
	localparam logic [mts_pkg::RUN_BITS-1:0] RUN_MAX = mts_pkg::RUN_BITS'(mts_pkg::MAX_RUN);
	localparam logic [mts_pkg::RUN_BITS-1:0] RUN_ONE = mts_pkg::RUN_BITS'(1);

	mts_state_t                         state_q, state_nxt;
	logic [mts_pkg::RUN_BITS-1:0]       cnt_q;
	logic [mts_pkg::DIV_CNT_BITS-1:0]   div_cnt_q;
	logic [mts_pkg::RUN_BITS-1:0]       n_sat;
	logic                               accept;

	// Saturate the run length
	assign n_sat  = (run_steps > RUN_MAX) ? RUN_MAX : run_steps;
	assign accept = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == mts_pkg::OP_REINIT) begin
						state_nxt = ST_REINIT;
					end else if (n_sat != '0) begin
						if (sts.stale) begin
							cmd.div_start = 1'b1;
							state_nxt     = ST_DIV;
						end else begin
							state_nxt = ST_RUN;
						end
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					cmd.div_done = 1'b1;
					state_nxt    = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.last = (cnt_q == RUN_ONE);
				if (sts.out_free) begin
					cmd.step_fire = 1'b1;
					if (cnt_q == RUN_ONE) state_nxt = ST_IDLE;
				end
			end
			ST_REINIT: begin
				cmd.last = 1'b1;
				if (sts.out_free) begin
					cmd.reinit_fire = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State, remaining steps and divider bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cnt_q <= n_sat;
			end else if (cmd.step_fire) begin
				cnt_q <= cnt_q - RUN_ONE;
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + mts_pkg::DIV_CNT_BITS'(1);
			end
		end
	end

endmodule

// File: sv/mts_dpath.sv
// ----------------------------------------------------------------------------
// mts_dpath: datapath of the multirate tick scheduler
// Configuration registers, step counter, one residue (step mod period) per
// tick with a bit-serial divider lane each, and the output register.
// ----------------------------------------------------------------------------
module mts_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mts_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  mts_pkg::mts_cmd_t                   cmd,
	output mts_pkg::mts_sts_t                   sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [mts_pkg::NUM_TICKS-1:0]       fire_mask,
	output logic                                is_reinit,
	output logic [mts_pkg::STEP_BITS-1:0]       end_step,
	output logic                                last
);

	localparam int PB = mts_pkg::PERIOD_BITS;
	localparam int NT = mts_pkg::NUM_TICKS;
	localparam int SB = mts_pkg::STEP_BITS;
	localparam int TR = mts_pkg::TICKS_PER_REG;

	// Configuration
	logic [mts_pkg::REG_BITS-1:0]   per_lo_q, per_hi_q;
	logic [mts_pkg::CONN_BITS-1:0]  conn_q;
	logic                           stale_q;

	// Counters and residues
	logic [SB-1:0]                  step_q, shift_q, step_nxt;
	logic [PB-1:0]                  rem_q   [NT];
	logic [PB-1:0]                  rem_div [NT];
	logic [PB-1:0]                  rem_run [NT];
	logic [PB-1:0]                  period  [NT];
	logic [PB:0]                    div_acc [NT];
	logic [PB:0]                    run_inc [NT];
	logic [NT-1:0]                  live, fire_vec;

	// Output register
	logic                           out_valid_q;
	logic [NT-1:0]                  fire_q;
	logic                           reinit_q, last_q;
	logic [SB-1:0]                  end_q;

	// Unpack periods and find the live ticks
	always_comb begin
		for (int i = 0; i < NT; i++) begin
			if (i < TR) period[i] = per_lo_q[i*PB +: PB];
			else        period[i] = per_hi_q[(i-TR)*PB +: PB];
			live[i] = (period[i] != '0) && conn_q[i];
		end
	end

	assign step_nxt = step_q + SB'(1);

	// Per-lane divider step and per-step residue advance
	always_comb begin
		for (int i = 0; i < NT; i++) begin
			div_acc[i] = {rem_q[i], shift_q[SB-1]};
			if (div_acc[i] >= {1'b0, period[i]}) rem_div[i] = PB'(div_acc[i] - {1'b0, period[i]});
			else                                 rem_div[i] = div_acc[i][PB-1:0];
			run_inc[i] = {1'b0, rem_q[i]} + (PB+1)'(1);
			// wrap of the step counter lands on zero, which every period divides
			if (step_nxt == '0 || run_inc[i] == {1'b0, period[i]}) rem_run[i] = '0;
			else                                                  rem_run[i] = run_inc[i][PB-1:0];
			fire_vec[i] = live[i] && (rem_run[i] == '0);
		end
	end

	// Configuration writes; a period change invalidates the residues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_lo_q <= '0;
			per_hi_q <= '0;
			conn_q   <= '0;
			stale_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mts_pkg::REG_PERIODS_LOW: begin
						per_lo_q <= cfg_wdata;
						stale_q  <= 1'b1;
					end
					mts_pkg::REG_PERIODS_HIGH: begin
						per_hi_q <= cfg_wdata;
						stale_q  <= 1'b1;
					end
					mts_pkg::REG_CONNECTED: begin
						conn_q <= cfg_wdata[mts_pkg::CONN_BITS-1:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.div_done || cmd.reinit_fire) begin
				stale_q <= 1'b0;
			end
		end
	end

	// Step counter, divider shifter and residues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			shift_q <= '0;
			for (int i = 0; i < NT; i++) rem_q[i] <= '0;
		end else begin
			if (cmd.reinit_fire) begin
				step_q <= '0;
				for (int i = 0; i < NT; i++) rem_q[i] <= '0;
			end else if (cmd.div_start) begin
				shift_q <= step_q;
				for (int i = 0; i < NT; i++) rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				shift_q <= {shift_q[SB-2:0], 1'b0};
				for (int i = 0; i < NT; i++) rem_q[i] <= rem_div[i];
			end else if (cmd.step_fire) begin
				step_q <= step_nxt;
				for (int i = 0; i < NT; i++) rem_q[i] <= rem_run[i];
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step_fire || cmd.reinit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.reinit_fire) begin
			fire_q   <= live;
			reinit_q <= 1'b1;
			end_q    <= '0;
			last_q   <= cmd.last;
		end else if (cmd.step_fire) begin
			fire_q   <= fire_vec;
			reinit_q <= 1'b0;
			end_q    <= step_nxt;
			last_q   <= cmd.last;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.stale    = stale_q;
	assign out_valid    = out_valid_q;
	assign fire_mask    = fire_q;
	assign is_reinit    = reinit_q;
	assign end_step     = end_q;
	assign last         = last_q;

endmodule

// File: sv/multirate_tick_scheduler.sv
// ----------------------------------------------------------------------------
// multirate_tick_scheduler: multi-rate tick scheduler top level
// Ten ticks with programmable periods and connected bits; run commands emit
// one fire mask per base step, reinit commands emit the live-tick mask.
// ----------------------------------------------------------------------------
// A run command of N steps (N saturated to 64, zero gives no result) emits
// one result per cycle, set by the single output register; a stalled output
// holds the sequence. Each tick keeps its residue of the step counter modulo
// its period, so a step needs only an increment and compare per tick. After
// a write to either period register the first run, unless a reinit comes
// first, opens with a recompute in which all ten lanes rebuild their
// residues by bit-serial division of the 32-bit step counter, one bit per
// cycle. A reinit leaves the residues current. A new command is taken once
// the previous one has loaded its last result.
module multirate_tick_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mts_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [mts_pkg::RUN_BITS-1:0]        run_steps,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mts_pkg::NUM_TICKS-1:0]       fire_mask,
	output logic                                is_reinit,
	output logic [mts_pkg::STEP_BITS-1:0]       end_step,
	output logic                                last
);

	mts_pkg::mts_cmd_t cmd;
	mts_pkg::mts_sts_t sts;

	// Command sequencer
	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.run_steps (run_steps),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Registers, residues and result register
	mts_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.fire_mask (fire_mask),
		.is_reinit (is_reinit),
		.end_step  (end_step),
		.last      (last)
	);

endmodule
